[rtl/lrast_pkg.sv]
// Shared types and constants for the 1 bpp line rasteriser.
// Holds the frame geometry, field widths, operation codes and pixel beat struct.
// No dependencies.
package lrast_pkg;

  localparam int ROW_BYTES   = 40;
  localparam int FRAME_BYTES = 9600;

  localparam int X_W    = 9;
  localparam int Y_W    = 8;
  localparam int BA_W   = 14;
  localparam int DATA_W = 8;

  localparam int FB_AW  = $clog2(FRAME_BYTES);
  localparam int PIX_AW = $clog2((2**Y_W - 1) * ROW_BYTES + 2**(X_W - 3));

  typedef enum logic [1:0] {
    OP_MOVE  = 2'd0,
    OP_LINE  = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef struct packed {
    logic           valid;
    logic           last;
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
  } pix_t;

  localparam logic [DATA_W-1:0] COL_MASK [8] = '{
    8'd128, 8'd64, 8'd32, 8'd16, 8'd8, 8'd4, 8'd2, 8'd1
  };

endpackage

[rtl/lrast_ram.sv]
// Single-port-write, single-port-read frame store with a registered read: data appears the cycle after the address.
// Depends on lrast_pkg for the depth and data width.
module lrast_ram (
  input  logic                        clk,
  input  logic                        we,
  input  logic [lrast_pkg::FB_AW-1:0]  waddr,
  input  logic [lrast_pkg::DATA_W-1:0] wdata,
  input  logic [lrast_pkg::FB_AW-1:0]  raddr,
  output logic [lrast_pkg::DATA_W-1:0] rdata
);
  import lrast_pkg::*;

  logic [DATA_W-1:0] mem [FRAME_BYTES];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/lrast_stepper.sv]
// Line stepper: walks the major axis one pixel per cycle and tracks the minor
// axis with a remainder accumulator, giving truncated-quotient coordinates.
// Depends on lrast_pkg for widths and the pixel beat struct.
module lrast_stepper (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [lrast_pkg::X_W-1:0]  x0,
  input  logic [lrast_pkg::Y_W-1:0]  y0,
  input  logic [lrast_pkg::X_W-1:0]  tx,
  input  logic [lrast_pkg::Y_W-1:0]  ty,
  output lrast_pkg::pix_t            pix
);
  import lrast_pkg::*;

  logic signed [X_W:0] dx;
  logic signed [Y_W:0] dy;
  logic [X_W-1:0]      adx;
  logic [Y_W-1:0]      ady;
  logic [X_W-1:0]      ady_x;
  logic                x_major;

  logic           busy_r;
  logic           xmaj_r;
  logic           maj_neg_r;
  logic           min_neg_r;
  logic [X_W-1:0] maj_r;
  logic [X_W-1:0] min_r;
  logic [X_W-1:0] cnt_r;
  logic [X_W-1:0] rem_r;
  logic [X_W-1:0] dmaj_r;
  logic [X_W-1:0] dmin_r;

  logic [X_W:0]   rem_sum;
  logic           rem_wrap;
  logic [X_W-1:0] rem_nxt;
  logic [X_W-1:0] maj_nxt;
  logic [X_W-1:0] min_nxt;

  always_comb begin
    dx      = $signed({1'b0, tx}) - $signed({1'b0, x0});
    dy      = $signed({1'b0, ty}) - $signed({1'b0, y0});
    adx     = dx[X_W] ? X_W'(-dx) : X_W'(dx);
    ady     = dy[Y_W] ? Y_W'(-dy) : Y_W'(dy);
    ady_x   = X_W'(ady);
    x_major = ady_x < adx;
  end

  always_comb begin
    rem_sum  = {1'b0, rem_r} + {1'b0, dmin_r};
    rem_wrap = rem_sum >= {1'b0, dmaj_r};
    rem_nxt  = rem_wrap ? X_W'(rem_sum - {1'b0, dmaj_r}) : X_W'(rem_sum);
    maj_nxt  = maj_neg_r ? maj_r - X_W'(1) : maj_r + X_W'(1);
    if (rem_wrap) begin
      min_nxt = min_neg_r ? min_r - X_W'(1) : min_r + X_W'(1);
    end else begin
      min_nxt = min_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && cnt_r == '0) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xmaj_r    <= x_major;
      maj_neg_r <= x_major ? dx[X_W] : dy[Y_W];
      min_neg_r <= x_major ? dy[Y_W] : dx[X_W];
      maj_r     <= x_major ? x0 : X_W'(y0);
      min_r     <= x_major ? X_W'(y0) : x0;
      cnt_r     <= x_major ? adx : ady_x;
      dmaj_r    <= x_major ? adx : ady_x;
      dmin_r    <= x_major ? ady_x : adx;
      rem_r     <= '0;
    end else if (busy_r && cnt_r != '0) begin
      maj_r <= maj_nxt;
      min_r <= min_nxt;
      rem_r <= rem_nxt;
      cnt_r <= cnt_r - X_W'(1);
    end
  end

  always_comb begin
    pix.valid = busy_r;
    pix.last  = busy_r && cnt_r == '0;
    pix.x     = xmaj_r ? maj_r : min_r;
    pix.y     = xmaj_r ? Y_W'(min_r) : Y_W'(maj_r);
  end

endmodule

[rtl/lrast_rmw.sv]
// Pixel read-modify-write path around the frame store, with forwarding of the
// previous write so that consecutive pixels in one byte merge correctly.
// Depends on lrast_pkg and instantiates lrast_ram.
module lrast_rmw (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lrast_pkg::pix_t             pix,
  input  logic [lrast_pkg::FB_AW-1:0]  host_raddr,
  input  logic                        sweep_we,
  input  logic [lrast_pkg::FB_AW-1:0]  sweep_addr,
  output logic [lrast_pkg::DATA_W-1:0] rd_data
);
  import lrast_pkg::*;

  logic [PIX_AW-1:0] pix_addr_full;
  logic              pix_in_range;

  logic              s1_vld_r;
  logic [FB_AW-1:0]  s1_addr_r;
  logic [DATA_W-1:0] s1_mask_r;

  logic              fwd_vld_r;
  logic [FB_AW-1:0]  fwd_addr_r;
  logic [DATA_W-1:0] fwd_data_r;

  logic [FB_AW-1:0]  ram_raddr;
  logic [DATA_W-1:0] ram_rdata;
  logic              ram_we;
  logic [FB_AW-1:0]  ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [DATA_W-1:0] merged;

  always_comb begin
    pix_addr_full = PIX_AW'(pix.x >> 3) + PIX_AW'(pix.y) * PIX_AW'(ROW_BYTES);
    pix_in_range  = pix_addr_full < FRAME_BYTES;
    ram_raddr     = pix.valid ? FB_AW'(pix_addr_full) : host_raddr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      fwd_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= pix.valid && pix_in_range;
      fwd_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_addr_r  <= FB_AW'(pix_addr_full);
    s1_mask_r  <= COL_MASK[pix.x[2:0]];
    fwd_addr_r <= s1_addr_r;
    fwd_data_r <= merged;
  end

  always_comb begin
    if (fwd_vld_r && fwd_addr_r == s1_addr_r) begin
      merged = fwd_data_r | s1_mask_r;
    end else begin
      merged = ram_rdata | s1_mask_r;
    end
    ram_we    = s1_vld_r || sweep_we;
    ram_waddr = s1_vld_r ? s1_addr_r : sweep_addr;
    ram_wdata = s1_vld_r ? merged : '0;
  end

  lrast_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_data = ram_rdata;

endmodule

[rtl/line_rasterizer_1bpp_core.sv]
// Top level of the 1 bpp line rasteriser: command sequencer, pen and result register.
// Depends on lrast_pkg and instantiates lrast_stepper and lrast_rmw.
//
// After reset the block sweeps the 9600-byte frame store to zero, one byte per
// cycle, and holds in_ready low for the whole sweep. Each command then gives
// exactly one result beat. A move goes straight to its result, a read passes
// the read-address and read-data states, a clear runs the same zeroing sweep,
// and a line writes one pixel read-modify-write per cycle through the single
// write port of the frame store, then drains. The next command is accepted
// while a previous result still waits in the output register.
module line_rasterizer_1bpp_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_operation,
  input  logic [lrast_pkg::X_W-1:0]    in_x_coord,
  input  logic [lrast_pkg::Y_W-1:0]    in_y_coord,
  input  logic [lrast_pkg::BA_W-1:0]   in_byte_address,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [lrast_pkg::DATA_W-1:0] out_read_data,
  output logic                        out_is_read_result
);
  import lrast_pkg::*;

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_LINE   = 7'b0000100,
    ST_DRAIN  = 7'b0001000,
    ST_READ   = 7'b0010000,
    ST_RDATA  = 7'b0100000,
    ST_RESULT = 7'b1000000
  } state_t;

  state_t            state_r;
  logic [X_W-1:0]    pen_x_r;
  logic [Y_W-1:0]    pen_y_r;
  logic [FB_AW-1:0]  clr_cnt_r;
  logic              clr_reply_r;
  logic [FB_AW-1:0]  cmd_addr_r;
  logic              rd_ok_r;
  logic [DATA_W-1:0] res_data_r;
  logic              res_is_read_r;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_read_data_r;
  logic              out_is_read_r;

  logic              in_fire;
  logic              line_start;
  logic              clr_last;
  logic              out_free;
  logic              sweep_we;
  pix_t              pix;
  logic [DATA_W-1:0] rd_data;

  always_comb begin
    in_ready   = state_r == ST_IDLE;
    in_fire    = in_valid && in_ready;
    line_start = in_fire && op_t'(in_operation) == OP_LINE;
    clr_last   = clr_cnt_r == FB_AW'(FRAME_BYTES - 1);
    out_free   = !out_valid_r || out_ready;
    sweep_we   = state_r == ST_CLEAR;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      clr_reply_r <= 1'b0;
      pen_x_r     <= '0;
      pen_y_r     <= '0;
    end else begin
      unique case (state_r)
        ST_CLEAR: begin
          if (clr_last) begin
            clr_cnt_r <= '0;
            state_r   <= clr_reply_r ? ST_RESULT : ST_IDLE;
          end else begin
            clr_cnt_r <= clr_cnt_r + FB_AW'(1);
          end
        end
        ST_IDLE: begin
          if (in_fire) begin
            unique case (op_t'(in_operation))
              OP_MOVE: begin
                pen_x_r <= in_x_coord;
                pen_y_r <= in_y_coord;
                state_r <= ST_RESULT;
              end
              OP_LINE: begin
                pen_x_r <= in_x_coord;
                pen_y_r <= in_y_coord;
                state_r <= ST_LINE;
              end
              OP_READ: begin
                state_r <= ST_READ;
              end
              OP_CLEAR: begin
                clr_reply_r <= 1'b1;
                state_r     <= ST_CLEAR;
              end
              default: begin
                state_r <= ST_IDLE;
              end
            endcase
          end
        end
        ST_LINE: begin
          if (pix.last) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state_r <= ST_RESULT;
        end
        ST_READ: begin
          state_r <= ST_RDATA;
        end
        ST_RDATA: begin
          state_r <= ST_RESULT;
        end
        ST_RESULT: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_RESULT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_addr_r    <= FB_AW'(in_byte_address);
      rd_ok_r       <= in_byte_address < FRAME_BYTES;
      res_data_r    <= '0;
      res_is_read_r <= 1'b0;
    end else if (state_r == ST_RDATA) begin
      res_data_r    <= rd_ok_r ? rd_data : '0;
      res_is_read_r <= 1'b1;
    end
    if (state_r == ST_RESULT && out_free) begin
      out_read_data_r <= res_data_r;
      out_is_read_r   <= res_is_read_r;
    end
  end

  lrast_stepper u_stepper (
    .clk   (clk),
    .rst_n (rst_n),
    .start (line_start),
    .x0    (pen_x_r),
    .y0    (pen_y_r),
    .tx    (in_x_coord),
    .ty    (in_y_coord),
    .pix   (pix)
  );

  lrast_rmw u_rmw (
    .clk        (clk),
    .rst_n      (rst_n),
    .pix        (pix),
    .host_raddr (cmd_addr_r),
    .sweep_we   (sweep_we),
    .sweep_addr (clr_cnt_r),
    .rd_data    (rd_data)
  );

  assign out_valid          = out_valid_r;
  assign out_read_data      = out_read_data_r;
  assign out_is_read_result = out_is_read_r;

  a_pix_only_in_line: assert property (@(posedge clk) disable iff (!rst_n)
    pix.valid |-> state_r == ST_LINE)
    else $error("Pixel beat issued outside line drawing.");

  a_line_starts: assert property (@(posedge clk) disable iff (!rst_n)
    line_start |=> pix.valid)
    else $error("Line command did not start the stepper.");

  a_drain_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DRAIN |-> !pix.valid)
    else $error("Stepper still active while draining.");

  a_nonread_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_is_read_r) |-> out_read_data_r == '0)
    else $error("Non-read result carries non-zero data.");

endmodule
